@@ hw/rtl/button_gesture_classifier_core_macros.svh @@
// Assertion macros shared by the button gesture classifier RTL.
// Define NO_ASSERTIONS to compile every check away.
// Depends on nothing.
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BGC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("button gesture classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("button gesture classifier check failed");

`else

`define BGC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/bgc_pkg.sv @@
// Types and constants of the button gesture classifier.
// Used by the channel interfaces, the classifier logic and the top level.
package bgc_pkg;

	// Gesture event codes carried in each result transaction.
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_DOWN     = 3'd1,
		EV_VOICE    = 3'd2,
		EV_VISION   = 3'd3,
		EV_HOLD_END = 3'd4,
		EV_PHOTO    = 3'd5,
		EV_TRIPLE   = 3'd6,
		EV_DISCARD  = 3'd7
	} gesture_t;

	// Configuration register indexes.
	localparam int unsigned CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_QUICK_TAP_LIMIT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_TAP_WINDOW      = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned TAP_W      = 2;

	// Register values after reset.
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
	localparam logic [CFG_DATA_W-1:0] QUICK_TAP_LIMIT_RST = 16'd300;
	localparam logic [CFG_DATA_W-1:0] TAP_WINDOW_RST      = 16'd400;

	// Tap counts with a meaning of their own.
	localparam logic [TAP_W-1:0] TAPS_NONE   = 2'd0;
	localparam logic [TAP_W-1:0] TAPS_ONE    = 2'd1;
	localparam logic [TAP_W-1:0] TAPS_TWO    = 2'd2;
	localparam logic [TAP_W-1:0] TAPS_THREE  = 2'd3;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] debounce_time;
		logic [CFG_DATA_W-1:0] quick_tap_limit;
		logic [CFG_DATA_W-1:0] tap_window;
	} cfg_t;

	// Classifier state carried from one sample to the next.
	typedef struct packed {
		logic              debounced_level;
		logic              previous_raw;
		logic [TIME_W-1:0] raw_change_time;
		logic [TIME_W-1:0] press_start_time;
		logic [TIME_W-1:0] quick_release_time;
		logic [TAP_W-1:0]  tap_counter;
		logic              hold_committed;
	} state_t;

	// One classified result.
	typedef struct packed {
		gesture_t         gesture_event;
		logic             hold_active;
		logic [TAP_W-1:0] taps_so_far;
	} result_t;

endpackage

@@ hw/rtl/bgc_in_if.sv @@
// Sample channel of the button gesture classifier: valid, ready and one raw sample.
// Depends on bgc_pkg.
interface bgc_in_if;
	logic                      valid;
	logic                      ready;
	logic                      raw_pressed;
	logic [bgc_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output raw_pressed, output now_ms, input ready);
	modport sink   (input valid, input raw_pressed, input now_ms, output ready);
endinterface

@@ hw/rtl/bgc_out_if.sv @@
// Event channel of the button gesture classifier: valid, ready and one result.
// Depends on bgc_pkg.
interface bgc_out_if;
	logic                      valid;
	logic                      ready;
	logic [2:0]                gesture_event;
	logic                      hold_active;
	logic [bgc_pkg::TAP_W-1:0] taps_so_far;

	modport source (output valid, output gesture_event, output hold_active,
		output taps_so_far, input ready);
	modport sink   (input valid, input gesture_event, input hold_active,
		input taps_so_far, output ready);
endinterface

@@ hw/rtl/bgc_classify.sv @@
// Next-state and event logic of the button gesture classifier for one sample.
// Depends on bgc_pkg.
module bgc_classify (
	input  bgc_pkg::cfg_t                  cfg,
	input  bgc_pkg::state_t                cur,
	input  logic                           raw_pressed,
	input  logic [bgc_pkg::TIME_W-1:0]     now_ms,
	output bgc_pkg::state_t                nxt,
	output bgc_pkg::result_t               res
);
	import bgc_pkg::*;

	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_press;
	logic [TIME_W-1:0] since_release;
	logic              steady;
	logic              hold_due;
	logic              in_window;
	gesture_t          ev;

	// Elapsed times wrap modulo 2^32; the three compares run in parallel.
	assign since_change  = now_ms - cur.raw_change_time;
	assign since_press   = now_ms - cur.press_start_time;
	assign since_release = now_ms - cur.quick_release_time;
	assign steady    = since_change >= {{(TIME_W-CFG_DATA_W){1'b0}}, cfg.debounce_time};
	assign hold_due  = since_press >= {{(TIME_W-CFG_DATA_W){1'b0}}, cfg.quick_tap_limit};
	assign in_window = (cur.tap_counter != TAPS_NONE) &&
		(since_release < {{(TIME_W-CFG_DATA_W){1'b0}}, cfg.tap_window});

	// Debounce, then classify press and release edges and the hold commit.
	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		if (raw_pressed != cur.previous_raw) begin
			nxt.previous_raw    = raw_pressed;
			nxt.raw_change_time = now_ms;
		end else if (!steady) begin
			ev = EV_NONE;
		end else if (raw_pressed == cur.debounced_level) begin
			if (cur.debounced_level && !cur.hold_committed && hold_due) begin
				nxt.hold_committed = 1'b1;
				ev = (cur.tap_counter == TAPS_TWO) ? EV_VISION : EV_VOICE;
			end
		end else begin
			nxt.debounced_level = raw_pressed;
			if (raw_pressed) begin
				// Press edge: start timing the press and count the tap.
				nxt.press_start_time = now_ms;
				nxt.hold_committed   = 1'b0;
				if (!in_window) begin
					nxt.tap_counter = TAPS_ONE;
				end else if (cur.tap_counter != TAPS_THREE) begin
					nxt.tap_counter = cur.tap_counter + TAPS_ONE;
				end
				ev = EV_DOWN;
			end else if (cur.hold_committed) begin
				// Release after a committed hold.
				nxt.tap_counter    = TAPS_NONE;
				nxt.hold_committed = 1'b0;
				ev = EV_HOLD_END;
			end else begin
				// Quick release: classify by the tap count.
				nxt.quick_release_time = now_ms;
				if (cur.tap_counter == TAPS_TWO) begin
					ev = EV_PHOTO;
				end else if (cur.tap_counter == TAPS_THREE) begin
					nxt.tap_counter = TAPS_NONE;
					ev = EV_TRIPLE;
				end else begin
					ev = EV_DISCARD;
				end
			end
		end
	end

	assign res.gesture_event = ev;
	assign res.hold_active   = nxt.debounced_level & nxt.hold_committed;
	assign res.taps_so_far   = nxt.tap_counter;

endmodule

@@ hw/rtl/button_gesture_classifier_core.sv @@
// Button gesture classifier: debounces raw button samples and reports press, hold,
// release and multi-tap events, one result transaction for every sample transaction.
// It takes one sample per clock cycle while the event side does not stall; each sample
// passes the input register, then the result register, and the classifier state update
// sets that rate. The user must write configuration registers through the plain write
// port only while no sample is in flight; the block does not enforce this. Depends on
// bgc_pkg, bgc_in_if, bgc_out_if, bgc_classify and the assertion macro header.
`include "button_gesture_classifier_core_macros.svh"

module button_gesture_classifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	bgc_in_if.sink                            samples,
	bgc_out_if.source                         events,
	input  logic                              cfg_wr_en,
	input  logic [bgc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bgc_pkg::*;

	cfg_t              cfg_q;
	state_t            state_q;
	state_t            state_nxt;
	result_t           res;
	logic              valid_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic              advance;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_TIME_RST;
			cfg_q.quick_tap_limit <= QUICK_TAP_LIMIT_RST;
			cfg_q.tap_window      <= TAP_WINDOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg_wdata;
				REG_QUICK_TAP_LIMIT: cfg_q.quick_tap_limit <= cfg_wdata;
				REG_TAP_WINDOW:      cfg_q.tap_window      <= cfg_wdata;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance       = valid_s1 && (!out_valid_q || events.ready);
	assign samples.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			raw_s1 <= samples.raw_pressed;
			now_s1 <= samples.now_ms;
		end
	end

	bgc_classify u_classify (
		.cfg         (cfg_q),
		.cur         (state_q),
		.raw_pressed (raw_s1),
		.now_ms      (now_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	// Classifier state is committed when its sample moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign events.valid         = out_valid_q;
	assign events.gesture_event = out_q.gesture_event;
	assign events.hold_active   = out_q.hold_active;
	assign events.taps_so_far   = out_q.taps_so_far;

	// A held sample stays in the input stage while the result side stalls.
	`BGC_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1)
	// A vision hold is only reported on the second tap.
	`BGC_ASSERT_SAME(a_vision_tap_two, clk, arst_n,
		out_valid_q && out_q.gesture_event == EV_VISION, out_q.taps_so_far == TAPS_TWO)
	// Ending a hold clears the tap count and the hold flag.
	`BGC_ASSERT_SAME(a_hold_end_clears, clk, arst_n,
		out_valid_q && out_q.gesture_event == EV_HOLD_END,
		out_q.taps_so_far == TAPS_NONE && !out_q.hold_active)
	// A triple tap clears the tap count.
	`BGC_ASSERT_SAME(a_triple_clears, clk, arst_n,
		out_valid_q && out_q.gesture_event == EV_TRIPLE, out_q.taps_so_far == TAPS_NONE)
	// A press edge always counts a tap and never starts out as a hold.
	`BGC_ASSERT_SAME(a_down_counts, clk, arst_n,
		out_valid_q && out_q.gesture_event == EV_DOWN,
		out_q.taps_so_far != TAPS_NONE && !out_q.hold_active)

endmodule

@@ test/button_gesture_classifier_core_tb.sv @@
// Self-checking testbench of the button gesture classifier core.
// Drives raw button samples, predicts every gesture result and compares it.
// Depends on bgc_pkg, bgc_in_if, bgc_out_if and button_gesture_classifier_core.
module button_gesture_classifier_core_tb;
	import bgc_pkg::*;

	localparam int unsigned HALF_PERIOD    = 5;
	localparam int unsigned RESET_CYCLES   = 3;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned STALL_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned IDLE_PERCENT   = 8;
	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bgc_in_if  sample_ch ();
	bgc_out_if gesture_ch ();

	button_gesture_classifier_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.events    (gesture_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted classifier state and register contents.
	state_t btn_state;
	cfg_t   cfg_copy;

	result_t           pending_gestures[$];
	logic [TIME_W-1:0] clock_ms;
	int unsigned       items_sent;
	int unsigned       mismatch_count;
	logic              src_idle_on;
	logic              snk_idle_on;
	int unsigned       sink_stall_req;
	int unsigned       sink_stall_left;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Computes the result of one sample and advances the predicted state.
	function automatic result_t predict_gesture(input logic raw, input logic [TIME_W-1:0] now);
		gesture_t          ev;
		logic [TIME_W-1:0] age;
		logic              in_window;
		result_t           res;
		ev = EV_NONE;
		if (raw != btn_state.previous_raw) begin
			// A raw change only restarts the debounce timer.
			btn_state.previous_raw = raw;
			btn_state.raw_change_time = now;
		end else begin
			age = now - btn_state.raw_change_time;
			if (age >= TIME_W'(cfg_copy.debounce_time)) begin
				if (raw == btn_state.debounced_level) begin
					// Steady level: a press may commit as a hold once.
					age = now - btn_state.press_start_time;
					if (btn_state.debounced_level && !btn_state.hold_committed &&
						age >= TIME_W'(cfg_copy.quick_tap_limit)) begin
						btn_state.hold_committed = 1'b1;
						ev = (btn_state.tap_counter == TAPS_TWO) ? EV_VISION : EV_VOICE;
					end
				end else begin
					btn_state.debounced_level = raw;
					if (raw) begin
						// Press edge: count taps inside the window.
						btn_state.press_start_time = now;
						btn_state.hold_committed = 1'b0;
						age = now - btn_state.quick_release_time;
						in_window = (btn_state.tap_counter != TAPS_NONE) &&
							(age < TIME_W'(cfg_copy.tap_window));
						if (!in_window)
							btn_state.tap_counter = TAPS_ONE;
						else if (btn_state.tap_counter != TAPS_THREE)
							btn_state.tap_counter = btn_state.tap_counter + TAPS_ONE;
						ev = EV_DOWN;
					end else if (btn_state.hold_committed) begin
						btn_state.tap_counter = TAPS_NONE;
						btn_state.hold_committed = 1'b0;
						ev = EV_HOLD_END;
					end else begin
						// Quick release: classify by the tap count.
						btn_state.quick_release_time = now;
						if (btn_state.tap_counter == TAPS_TWO) begin
							ev = EV_PHOTO;
						end else if (btn_state.tap_counter == TAPS_THREE) begin
							btn_state.tap_counter = TAPS_NONE;
							ev = EV_TRIPLE;
						end else begin
							ev = EV_DISCARD;
						end
					end
				end
			end
		end
		res.gesture_event = ev;
		res.hold_active = btn_state.debounced_level && btn_state.hold_committed;
		res.taps_so_far = btn_state.tap_counter;
		return res;
	endfunction

	// Offers one sample until the block takes it, then records its prediction.
	task automatic send_sample(input logic raw, input logic [TIME_W-1:0] now);
		while (src_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_pressed <= raw;
		sample_ch.now_ms <= now;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		pending_gestures.push_back(predict_gesture(raw, now));
		items_sent++;
	endtask

	task automatic sample_at(input logic raw, input int unsigned delta_ms);
		clock_ms = clock_ms + delta_ms;
		send_sample(raw, clock_ms);
	endtask

	// Stops offering samples and waits until every predicted result has arrived.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		case (addr)
			REG_DEBOUNCE_TIME:   cfg_copy.debounce_time = data;
			REG_QUICK_TAP_LIMIT: cfg_copy.quick_tap_limit = data;
			REG_TAP_WINDOW:      cfg_copy.tap_window = data;
			default: ;
		endcase
	endtask

	// Writes all registers while the block is idle, plus one ignored index.
	task automatic apply_config(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] qtl,
		input logic [CFG_DATA_W-1:0] win);
		drain_results();
		write_reg(REG_DEBOUNCE_TIME, deb);
		write_reg(REG_QUICK_TAP_LIMIT, qtl);
		write_reg(REG_TAP_WINDOW, win);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
		cfg_wr_en <= 1'b0;
	endtask

	// Holds one level for about dur_ms, with a sample at or up to 2 ms after the debounce time.
	task automatic drive_level(input logic lvl, input int unsigned dur_ms);
		int unsigned elapsed;
		int unsigned rem;
		int unsigned step;
		elapsed = 0;
		sample_at(lvl, $urandom_range(1, 3));
		step = 32'(cfg_copy.debounce_time) + $urandom_range(0, 2);
		while (elapsed < dur_ms) begin
			rem = dur_ms - elapsed;
			if (step > rem)
				step = rem;
			elapsed += step;
			sample_at(lvl, step);
			rem = dur_ms - elapsed;
			step = ($urandom_range(0, 1) == 0) ? rem : $urandom_range(1, (rem > 0) ? rem : 1);
		end
	endtask

	// Contact bounce: a few random levels, mostly shorter than the debounce time.
	task automatic bounce_raw(input int unsigned deb);
		int unsigned n;
		int unsigned k;
		n = $urandom_range(0, 2);
		for (k = 0; k < n; k++)
			sample_at(1'($urandom_range(0, 1)), $urandom_range(0, deb / 2 + 1));
	endtask

	// One to three taps; the last one may be held and is followed by a long gap.
	task automatic random_gesture();
		int unsigned deb;
		int unsigned qtl;
		int unsigned win;
		int unsigned taps;
		int unsigned k;
		deb = 32'(cfg_copy.debounce_time);
		qtl = 32'(cfg_copy.quick_tap_limit);
		win = 32'(cfg_copy.tap_window);
		taps = $urandom_range(1, 3);
		for (k = 0; k < taps; k++) begin
			bounce_raw(deb);
			if (k == taps - 1 && $urandom_range(0, 2) == 0)
				drive_level(1'b1, deb + qtl + $urandom_range(0, qtl / 2 + 2));
			else
				drive_level(1'b1, deb + $urandom_range(0, qtl));
			bounce_raw(deb);
			if (k == taps - 1)
				drive_level(1'b0, deb + win + $urandom_range(0, win / 2 + 2));
			else
				drive_level(1'b0, deb + $urandom_range(0, win));
		end
	endtask

	// Mostly well-formed gestures, with noise bursts and jumps of the timestamp.
	task automatic run_random_gestures(input int unsigned n);
		int unsigned target;
		int unsigned span;
		int unsigned burst;
		int unsigned k;
		target = items_sent + n;
		while (items_sent < target) begin
			span = 32'(cfg_copy.debounce_time) + 32'(cfg_copy.quick_tap_limit) +
				32'(cfg_copy.tap_window);
			case ($urandom_range(0, 9))
				8: begin
					burst = $urandom_range(1, 6);
					for (k = 0; k < burst; k++)
						sample_at(1'($urandom_range(0, 1)),
							$urandom_range(0, 2 * 32'(cfg_copy.debounce_time) + 2));
				end
				9: begin
					if ($urandom_range(0, 1) == 0)
						clock_ms = $urandom();
					else
						clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
					random_gesture();
				end
				default: begin
					random_gesture();
				end
			endcase
		end
	endtask

	// Directed taps for the reset limits of 30, 300 and 400 ms.
	task automatic quick_tap();
		sample_at(1'b1, 10);
		sample_at(1'b1, 40);
		sample_at(1'b0, 10);
		sample_at(1'b0, 40);
	endtask

	task automatic held_tap();
		sample_at(1'b1, 10);
		sample_at(1'b1, 40);
		sample_at(1'b1, 300);
		sample_at(1'b0, 10);
		sample_at(1'b0, 40);
	endtask

	task automatic test_directed_gestures();
		// First press at time zero, a sample before it is steady, and a hold
		// committed exactly at the quick-tap limit: voice hold, then its end.
		clock_ms = '0;
		send_sample(1'b1, clock_ms);
		sample_at(1'b1, 10);
		sample_at(1'b1, 30);
		sample_at(1'b1, 300);
		sample_at(1'b0, 10);
		sample_at(1'b0, 40);
		// Discard, photo and triple across the timestamp wrap.
		clock_ms = 32'hFFFF_FF80;
		quick_tap();
		quick_tap();
		quick_tap();
		// A quick tap followed by a held second tap gives a vision hold.
		quick_tap();
		held_tap();
	endtask

	task automatic test_default_limits();
		run_random_gestures(150);
	endtask

	task automatic test_zero_limits();
		apply_config('0, '0, '0);
		run_random_gestures(150);
	endtask

	task automatic test_max_limits();
		apply_config('1, '1, '1);
		run_random_gestures(150);
	endtask

	// Small random limits with no idling on either side.
	task automatic test_steady_flow();
		apply_config(CFG_DATA_W'($urandom_range(0, 40)), CFG_DATA_W'($urandom_range(0, 200)),
			CFG_DATA_W'($urandom_range(0, 300)));
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		run_random_gestures(150);
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
	endtask

	// The receiver holds off while samples keep coming, then the sender drains.
	task automatic test_backpressure();
		src_idle_on = 1'b0;
		sink_stall_req = STALL_CYCLES;
		run_random_gestures(60);
		drain_results();
		src_idle_on = 1'b1;
	endtask

	task automatic test_random_limits();
		apply_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
		run_random_gestures(100);
	endtask

	// Result receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (sink_stall_req != 0) begin
			sink_stall_left = sink_stall_req;
			sink_stall_req = 0;
		end
		if (sink_stall_left != 0) begin
			sink_stall_left--;
			gesture_ch.ready <= 1'b0;
		end else begin
			gesture_ch.ready <= !(snk_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Each result transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && gesture_ch.valid && gesture_ch.ready) begin
			if (pending_gestures.size() == 0) begin
				note_mismatch($sformatf("unexpected result: event %0d hold %0b taps %0d",
					gesture_ch.gesture_event, gesture_ch.hold_active, gesture_ch.taps_so_far));
			end else begin
				want = pending_gestures.pop_front();
				if (gesture_ch.gesture_event !== want.gesture_event ||
					gesture_ch.hold_active !== want.hold_active ||
					gesture_ch.taps_so_far !== want.taps_so_far)
					note_mismatch($sformatf(
						"result mismatch: expected event %0d hold %0b taps %0d, got event %0d hold %0b taps %0d",
						want.gesture_event, want.hold_active, want.taps_so_far,
						gesture_ch.gesture_event, gesture_ch.hold_active, gesture_ch.taps_so_far));
			end
		end
	end

	// Ends the run when no transaction happens on either channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (gesture_ch.valid && gesture_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = REG_DEBOUNCE_TIME;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_pressed = 1'b0;
		sample_ch.now_ms = '0;
		gesture_ch.ready = 1'b0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		sink_stall_req = 0;
		sink_stall_left = 0;
		items_sent = 0;
		mismatch_count = 0;
		clock_ms = '0;
		btn_state = '0;
		cfg_copy.debounce_time = DEBOUNCE_TIME_RST;
		cfg_copy.quick_tap_limit = QUICK_TAP_LIMIT_RST;
		cfg_copy.tap_window = TAP_WINDOW_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_gestures();
		test_default_limits();
		test_zero_limits();
		test_max_limits();
		test_steady_flow();
		test_backpressure();
		test_random_limits();

		drain_results();
		if (mismatch_count == 0 && pending_gestures.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
